// File: rtl/dtq_pkg.sv
package dtq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 48;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int SLOT_BITS = 4;
    localparam int PERIOD_W  = 32;
    localparam int DELAY_W   = 48;
    localparam int REQ_W     = 3;
    localparam int MAX_RES   = 16;
    localparam int CNT_W     = $clog2(MAX_RES + 1);

    localparam logic [DELAY_W-1:0] DELAY_ALL = '1;

    // request codes on the input port
    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REFRESH = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd5;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_ADD,
        OP_CANCEL,
        OP_REFRESH,
        OP_RESET,
        OP_QUERY,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [SLOT_BITS-1:0] slot;
        logic [PERIOD_W-1:0]  period;
        logic                 recurring;
        logic                 restart;
    } t_req;

    // saturating add of a period to a time value
    function automatic t_time sat_add(input t_time a, input logic [PERIOD_W-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        sat_add = s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    function automatic t_op classify(input logic [REQ_W-1:0] code);
        t_op op;
        unique case (code)
            REQ_TICK:    op = OP_TICK;
            REQ_ADD:     op = OP_ADD;
            REQ_CANCEL:  op = OP_CANCEL;
            REQ_REFRESH: op = OP_REFRESH;
            REQ_RESET:   op = OP_RESET;
            REQ_QUERY:   op = OP_QUERY;
            default:     op = OP_BAD;
        endcase
        classify = op;
    endfunction

endpackage

// File: rtl/dtq_front.sv
module dtq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dtq_pkg::REQ_W-1:0]     i_req_type,
    input  logic [dtq_pkg::SLOT_BITS-1:0] i_slot,
    input  logic [dtq_pkg::PERIOD_W-1:0]  i_period_ms,
    input  logic                          i_recurring,
    input  logic                          i_restart,
    output logic                          o_req_valid,
    output dtq_pkg::t_req                 o_req,
    input  logic                          i_pop
);
    import dtq_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall     = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign push        = i_valid && !o_stall;
    assign pop         = i_pop && o_req_valid;

    // store classified transactions
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: classify(i_req_type), slot: i_slot, period: i_period_ms,
                           recurring: i_recurring, restart: i_restart};
        end
    end

    // advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            if (push && !pop)      r_cnt <= r_cnt + 2'd1;
            else if (pop && !push) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

// File: rtl/dtq_back.sv
module dtq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  dtq_pkg::t_req                 i_req,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dtq_pkg::SLOT_BITS-1:0] o_slot_id,
    output logic                          o_ok,
    output logic                          o_expired,
    output logic                          o_front_notice,
    output logic [dtq_pkg::DELAY_W-1:0]   o_next_delay,
    output logic                          o_last
);
    import dtq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT, S_SHIFT, S_ESCAN, S_MSCAN, S_QDONE, S_TSCAN, S_TEMIT, S_EMIT
    } t_state;

    t_state                r_state;
    t_req                  r_req;
    t_time                 r_now;
    logic [NUM_SLOTS-1:0]  r_active;
    t_time                 r_dl  [NUM_SLOTS];
    logic [PERIOD_W-1:0]   r_per [NUM_SLOTS];
    logic                  r_rec [NUM_SLOTS];
    logic                  r_pend;
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]     r_tgt;
    logic [NUM_SLOTS-1:0]  r_mask;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_flag;
    logic                  r_any;
    t_time                 r_best;
    t_time                 r_newdl;
    logic                  r_up;
    logic [PERIOD_W-1:0]   r_delta;
    logic [SLOT_BITS-1:0]  r_rid;
    logic                  r_rok;
    logic                  r_rfn;
    logic [DELAY_W-1:0]    r_rnd;

    t_time                 rd_dl;
    logic [PERIOD_W-1:0]   rd_per;
    logic                  rd_rec;
    logic                  emit_ok;
    logic                  emit_now;
    logic                  last_idx;
    logic                  free_any;
    logic [SLOT_W-1:0]     free_idx;
    t_time                 add_dl;
    logic                  in_range;
    logic                  slot_valid;
    logic                  earlier;
    logic                  flag_n;
    logic                  higher;
    logic                  due;
    logic [NUM_SLOTS-1:0]  mask_n;
    t_time                 shift_dl;
    t_time                 diff;
    logic [63:0]           diff64;
    logic [DELAY_W-1:0]    delay;
    logic                  t_emit;
    logic                  t_step;

    // single read port at the scan index
    assign rd_dl    = r_dl[r_idx];
    assign rd_per   = r_per[r_idx];
    assign rd_rec   = r_rec[r_idx];
    assign emit_ok  = !o_valid || !i_stall;
    assign last_idx = (r_idx == SLOT_W'(NUM_SLOTS - 1));
    assign o_pop    = (r_state == S_IDLE) && i_req_valid;
    assign add_dl   = sat_add(r_now, i_req.period);

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
    end

    assign in_range   = ({1'b0, r_req.slot} < (SLOT_BITS + 1)'(NUM_SLOTS));
    assign slot_valid = in_range && r_active[r_idx];

    // earliest check: lower deadline, or equal deadline at a lower slot
    assign earlier = r_active[r_idx] && (r_idx != r_tgt) &&
                     ((rd_dl < r_newdl) || ((rd_dl == r_newdl) && (r_idx < r_tgt)));
    assign flag_n  = r_flag && !earlier;

    assign due    = r_active[r_idx] && (rd_dl <= r_now);
    always_comb begin
        mask_n        = r_mask;
        mask_n[r_idx] = due;
    end
    assign higher = |((r_mask >> r_idx) >> 1);
    assign t_emit = r_mask[r_idx] && (r_cnt < CNT_W'(MAX_RES));
    assign t_step = !t_emit || emit_ok;

    // load the output register this cycle
    assign emit_now = ((r_state == S_TEMIT) && t_step && t_emit) ||
                      ((r_state == S_EMIT) && emit_ok);

    assign shift_dl = r_up ? sat_add(rd_dl, r_delta) :
                      ((rd_dl >= TIME_BITS'(r_delta)) ? rd_dl - TIME_BITS'(r_delta) : '0);

    // time left to the earliest deadline
    assign diff   = r_best - r_now;
    assign diff64 = 64'(diff);
    always_comb begin
        if (!r_any)                    delay = DELAY_ALL;
        else if (r_best <= r_now)      delay = '0;
        else if (diff64 >= 64'(DELAY_ALL)) delay = DELAY_ALL - DELAY_W'(1);
        else                           delay = DELAY_W'(diff64);
    end

    // slot table writes
    always_ff @(posedge i_clk) begin
        priority case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_req.op == OP_ADD && free_any) begin
                    r_dl[free_idx]  <= add_dl;
                    r_per[free_idx] <= i_req.period;
                    r_rec[free_idx] <= i_req.recurring;
                end
            end
            S_SLOT: begin
                if (slot_valid && r_req.op == OP_REFRESH)
                    r_dl[r_idx] <= sat_add(r_now, rd_per);
                if (slot_valid && r_req.op == OP_RESET && r_req.restart) begin
                    r_dl[r_idx]  <= sat_add(r_now, r_req.period);
                    r_per[r_idx] <= r_req.period;
                end
            end
            S_SHIFT: begin
                r_dl[r_idx]  <= shift_dl;
                r_per[r_idx] <= r_req.period;
            end
            S_TEMIT: begin
                if (t_step && r_mask[r_idx] && rd_rec)
                    r_dl[r_idx] <= sat_add(r_now, rd_per);
            end
            default: ;
        endcase
    end

    // request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_active <= '0;
            r_pend   <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (emit_now)      o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        r_rfn <= 1'b0;
                        r_rnd <= '0;
                        unique case (i_req.op)
                            OP_TICK: begin
                                r_now   <= r_now + TIME_BITS'(1);
                                r_rid   <= '0;
                                r_rok   <= 1'b0;
                                r_idx   <= '0;
                                r_mask  <= '0;
                                r_state <= S_TSCAN;
                            end
                            OP_ADD: begin
                                r_idx <= '0;
                                if (free_any) begin
                                    r_active[free_idx] <= 1'b1;
                                    r_tgt   <= free_idx;
                                    r_newdl <= add_dl;
                                    r_flag  <= 1'b1;
                                    r_rid   <= SLOT_BITS'(free_idx);
                                    r_rok   <= 1'b1;
                                    r_state <= S_ESCAN;
                                end else begin
                                    r_rid   <= '0;
                                    r_rok   <= 1'b0;
                                    r_state <= S_EMIT;
                                end
                            end
                            OP_QUERY: begin
                                r_pend  <= 1'b0;
                                r_idx   <= '0;
                                r_any   <= 1'b0;
                                r_rid   <= '0;
                                r_rok   <= 1'b1;
                                r_state <= S_MSCAN;
                            end
                            OP_CANCEL, OP_REFRESH, OP_RESET: begin
                                r_idx   <= SLOT_W'(i_req.slot);
                                r_rid   <= '0;
                                r_rok   <= 1'b0;
                                r_state <= S_SLOT;
                            end
                            default: begin
                                r_rid   <= '0;
                                r_rok   <= 1'b0;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SLOT: begin
                    r_rok <= slot_valid;
                    if (slot_valid && r_req.op == OP_CANCEL)
                        r_active[r_idx] <= 1'b0;
                    if (slot_valid && r_req.op == OP_RESET) begin
                        r_tgt <= r_idx;
                        if (r_req.restart) begin
                            r_newdl <= sat_add(r_now, r_req.period);
                            r_idx   <= '0;
                            r_flag  <= 1'b1;
                            r_state <= S_ESCAN;
                        end else begin
                            r_up    <= (r_req.period >= rd_per);
                            r_delta <= (r_req.period >= rd_per) ? r_req.period - rd_per
                                                                : rd_per - r_req.period;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_SHIFT: begin
                    r_newdl <= shift_dl;
                    r_idx   <= '0;
                    r_flag  <= 1'b1;
                    r_state <= S_ESCAN;
                end
                S_ESCAN: begin
                    r_flag <= flag_n;
                    r_idx  <= r_idx + SLOT_W'(1);
                    if (last_idx) begin
                        r_rfn   <= flag_n && !r_pend;
                        if (flag_n && !r_pend) r_pend <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_MSCAN: begin
                    if (r_active[r_idx] && (!r_any || rd_dl < r_best)) begin
                        r_best <= rd_dl;
                        r_any  <= 1'b1;
                    end
                    r_idx <= r_idx + SLOT_W'(1);
                    if (last_idx) r_state <= S_QDONE;
                end
                S_QDONE: begin
                    r_rnd   <= delay;
                    r_state <= S_EMIT;
                end
                S_TSCAN: begin
                    r_mask <= mask_n;
                    r_idx  <= r_idx + SLOT_W'(1);
                    if (last_idx) begin
                        r_cnt <= '0;
                        if (mask_n == '0) begin
                            r_rok   <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_TEMIT;
                        end
                    end
                end
                S_TEMIT: begin
                    if (t_step) begin
                        if (r_mask[r_idx] && !rd_rec) r_active[r_idx] <= 1'b0;
                        if (t_emit) begin
                            o_slot_id      <= SLOT_BITS'(r_idx);
                            o_ok           <= 1'b1;
                            o_expired      <= 1'b1;
                            o_front_notice <= 1'b0;
                            o_next_delay   <= '0;
                            o_last         <= !higher || (r_cnt == CNT_W'(MAX_RES - 1));
                            r_cnt          <= r_cnt + CNT_W'(1);
                        end
                        r_idx <= r_idx + SLOT_W'(1);
                        if (last_idx) r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        o_slot_id      <= r_rid;
                        o_ok           <= r_rok;
                        o_expired      <= 1'b0;
                        o_front_notice <= r_rfn;
                        o_next_delay   <= r_rnd;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/deadline_timer_queue_core.sv
// Channel | Direction | Handshake        | Payload
// request | in        | i_valid/o_stall  | i_req_type i_slot i_period_ms i_recurring i_restart
// result  | out       | o_valid/i_stall  | o_slot_id o_ok o_expired o_front_notice
//         |           |                  | o_next_delay o_last
//
// Cancel, refresh, a reset of an inactive slot, bad codes and add on a full table need no
// scan. Add, reset and query scan the deadline table one slot a cycle; a reset with shift
// first adjusts the deadline, and query then loads the delay. Tick scans once to mark due
// slots and, if any are due, walks the table again to report them; i_stall holds that walk.
// A two-entry request queue decouples intake from execution; o_stall rises when full.
// Results sit in an output register; i_stall holds it and pauses the sequencer.
// i_rst_n is synchronous: it clears the clock, the active marks and the notice flag.
module deadline_timer_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dtq_pkg::REQ_W-1:0]     i_req_type,
    input  logic [dtq_pkg::SLOT_BITS-1:0] i_slot,
    input  logic [dtq_pkg::PERIOD_W-1:0]  i_period_ms,
    input  logic                          i_recurring,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dtq_pkg::SLOT_BITS-1:0] o_slot_id,
    output logic                          o_ok,
    output logic                          o_expired,
    output logic                          o_front_notice,
    output logic [dtq_pkg::DELAY_W-1:0]   o_next_delay,
    output logic                          o_last
);
    import dtq_pkg::*;

    logic req_valid;
    t_req req;
    logic pop;

    // intake and classify
    dtq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_slot      (i_slot),
        .i_period_ms (i_period_ms),
        .i_recurring (i_recurring),
        .i_restart   (i_restart),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_pop       (pop)
    );

    // execute against the slot table
    dtq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .i_req          (req),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_slot_id      (o_slot_id),
        .o_ok           (o_ok),
        .o_expired      (o_expired),
        .o_front_notice (o_front_notice),
        .o_next_delay   (o_next_delay),
        .o_last         (o_last)
    );

    // expiry reports are always successful
    a_expired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_expired |-> o_ok)
        else $error("expired result without ok");

    // only tick expiry bursts span several results
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_expired |-> o_last)
        else $error("non-expiry result not marked last");

    // a front notice comes only on a successful single result
    a_notice_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_front_notice |-> o_ok && o_last && !o_expired && o_next_delay == '0)
        else $error("front notice on a bad result");

endmodule

// File: tb/tb_deadline_timer_queue_core.sv
module tb_deadline_timer_queue_core;
    import dtq_pkg::*;

    // codes that the block does not know
    localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]     code;
        logic [SLOT_BITS-1:0] slot;
        logic [PERIOD_W-1:0]  period;
        logic                 recurring;
        logic                 restart;
    } t_timer_req;

    typedef struct {
        logic [SLOT_BITS-1:0] slot_id;
        logic                 ok;
        logic                 expired;
        logic                 front_notice;
        logic [DELAY_W-1:0]   next_delay;
        logic                 last;
    } t_timer_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic [SLOT_BITS-1:0] i_slot;
    logic [PERIOD_W-1:0]  i_period_ms;
    logic                 i_recurring;
    logic                 i_restart;
    logic                 o_valid;
    logic                 i_stall;
    logic [SLOT_BITS-1:0] o_slot_id;
    logic                 o_ok;
    logic                 o_expired;
    logic                 o_front_notice;
    logic [DELAY_W-1:0]   o_next_delay;
    logic                 o_last;

    deadline_timer_queue_core i_dut (.*);

    // predicted timer table
    t_time                now_ms;
    logic                 active[NUM_SLOTS];
    t_time                deadline[NUM_SLOTS];
    logic [PERIOD_W-1:0]  period[NUM_SLOTS];
    logic                 recur[NUM_SLOTS];
    logic                 notice_pending;

    t_timer_req  request_q[$];
    t_timer_res  result_q[$];
    int          idle_pct;
    int          stall_pct;
    logic        hold_requests;
    int          n_failures;
    int          n_requests;
    int          n_results;
    int          n_expiries;
    int          n_notices;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_time time_plus(input t_time t, input logic [PERIOD_W-1:0] inc);
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS + 1)'(inc);
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    function automatic logic is_earliest(input int k);
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (j != k && active[j]) begin
                if (deadline[j] < deadline[k]) return 1'b0;
                if (deadline[j] == deadline[k] && j < k) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic take_notice(input int k);
        if (is_earliest(k) && !notice_pending) begin
            notice_pending = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void queue_result(input int id, input logic ok, input logic ex,
                                         input logic fn, input t_time nd, input logic lst);
        t_timer_res r;
        r.slot_id      = SLOT_BITS'(id);
        r.ok           = ok;
        r.expired      = ex;
        r.front_notice = fn;
        r.next_delay   = nd;
        r.last         = lst;
        result_q = {result_q, r};
    endfunction

    // advance the predicted table by one request and queue its results
    function automatic void predict_timer(input t_timer_req rq);
        logic   due[NUM_SLOTS];
        logic   ok;
        logic   fn;
        logic   any;
        int     n;
        int     s;
        t_time  best;
        t_time  nd;
        t_time  d;
        s  = int'(rq.slot);
        ok = active[s];
        fn = 1'b0;
        case (rq.code)
            REQ_TICK: begin
                n = 0;
                now_ms = now_ms + 1'b1;
                for (int k = 0; k < NUM_SLOTS; k++)
                    due[k] = active[k] && deadline[k] <= now_ms;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (due[k]) begin
                        if (recur[k]) deadline[k] = time_plus(now_ms, period[k]);
                        else active[k] = 1'b0;
                        if (n < MAX_RES) begin
                            queue_result(k, 1'b1, 1'b1, 1'b0, '0, 1'b0);
                            n++;
                        end
                    end
                end
                n_expiries += n;
                if (n == 0) queue_result(0, 1'b1, 1'b0, 1'b0, '0, 1'b1);
                else result_q[$].last = 1'b1;
            end
            REQ_ADD: begin
                n = -1;
                for (int k = 0; k < NUM_SLOTS; k++)
                    if (n < 0 && !active[k]) n = k;
                if (n < 0) begin
                    queue_result(0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    active[n]   = 1'b1;
                    deadline[n] = time_plus(now_ms, rq.period);
                    period[n]   = rq.period;
                    recur[n]    = rq.recurring;
                    queue_result(n, 1'b1, 1'b0, take_notice(n), '0, 1'b1);
                end
            end
            REQ_CANCEL: begin
                if (ok) active[s] = 1'b0;
                queue_result(0, ok, 1'b0, 1'b0, '0, 1'b1);
            end
            REQ_REFRESH: begin
                if (ok) deadline[s] = time_plus(now_ms, period[s]);
                queue_result(0, ok, 1'b0, 1'b0, '0, 1'b1);
            end
            REQ_RESET: begin
                if (ok) begin
                    if (rq.restart) begin
                        deadline[s] = time_plus(now_ms, rq.period);
                    end else if (rq.period >= period[s]) begin
                        deadline[s] = time_plus(deadline[s], rq.period - period[s]);
                    end else begin
                        d = t_time'(period[s] - rq.period);
                        deadline[s] = (deadline[s] >= d) ? deadline[s] - d : '0;
                    end
                    period[s] = rq.period;
                    fn = take_notice(s);
                end
                queue_result(0, ok, 1'b0, fn, '0, 1'b1);
            end
            REQ_QUERY: begin
                any  = 1'b0;
                best = '0;
                notice_pending = 1'b0;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (active[k] && (!any || deadline[k] < best)) begin
                        best = deadline[k];
                        any  = 1'b1;
                    end
                end
                if (!any) nd = DELAY_ALL;
                else if (best > now_ms) begin
                    nd = best - now_ms;
                    if (nd == DELAY_ALL) nd = DELAY_ALL - 1'b1;
                end else nd = '0;
                queue_result(0, 1'b1, 1'b0, 1'b0, nd, 1'b1);
            end
            default: queue_result(0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DELAY_W-1:0] got,
                                   input logic [DELAY_W-1:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, want);
        n_failures++;
    endtask

    // drive requests; predict each transaction as it is accepted
    always @(posedge i_clk) begin
        t_timer_req rq;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                rq.code      = i_req_type;
                rq.slot      = i_slot;
                rq.period    = i_period_ms;
                rq.recurring = i_recurring;
                rq.restart   = i_restart;
                predict_timer(rq);
                n_requests++;
            end
            if (!i_valid || !o_stall) begin
                if (request_q.size() > 0 && !hold_requests &&
                    $urandom_range(99) >= idle_pct) begin
                    rq = request_q.pop_front();
                    i_req_type  <= rq.code;
                    i_slot      <= rq.slot;
                    i_period_ms <= rq.period;
                    i_recurring <= rq.recurring;
                    i_restart   <= rq.restart;
                    i_valid     <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // stall the result channel at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_timer_res r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result slot_id", DELAY_W'(o_slot_id), '0);
            end else begin
                r = result_q.pop_front();
                if (o_slot_id !== r.slot_id)
                    report_mismatch("slot_id", DELAY_W'(o_slot_id), DELAY_W'(r.slot_id));
                if (o_ok !== r.ok)
                    report_mismatch("ok", DELAY_W'(o_ok), DELAY_W'(r.ok));
                if (o_expired !== r.expired)
                    report_mismatch("expired", DELAY_W'(o_expired), DELAY_W'(r.expired));
                if (o_front_notice !== r.front_notice)
                    report_mismatch("front_notice", DELAY_W'(o_front_notice),
                                    DELAY_W'(r.front_notice));
                if (o_next_delay !== r.next_delay)
                    report_mismatch("next_delay", o_next_delay, r.next_delay);
                if (o_last !== r.last)
                    report_mismatch("last", DELAY_W'(o_last), DELAY_W'(r.last));
                if (r.front_notice) n_notices++;
            end
            n_results++;
        end
    end

    task automatic add_req(input logic [REQ_W-1:0] code, input int slot,
                           input logic [PERIOD_W-1:0] per, input logic rec, input logic fnow);
        t_timer_req rq;
        rq.code      = code;
        rq.slot      = SLOT_BITS'(slot);
        rq.period    = per;
        rq.recurring = rec;
        rq.restart   = fnow;
        request_q = {request_q, rq};
    endtask

    // hold until every queued request is accepted and every result has come
    task automatic drain();
        while (request_q.size() > 0 || i_valid || result_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic random_requests(input int count);
        int pick;
        logic [PERIOD_W-1:0] per;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            per  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(12);
            if (pick < 40)      add_req(REQ_TICK, $urandom_range(15), $urandom(), 1'b0, 1'b0);
            else if (pick < 60) add_req(REQ_ADD, $urandom_range(15), per,
                                        1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (pick < 68) add_req(REQ_CANCEL, $urandom_range(15), per, 1'b0, 1'b0);
            else if (pick < 76) add_req(REQ_REFRESH, $urandom_range(15), per, 1'b0, 1'b0);
            else if (pick < 87) add_req(REQ_RESET, $urandom_range(15), per,
                                        1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (pick < 97) add_req(REQ_QUERY, $urandom_range(15), per, 1'b0, 1'b0);
            else add_req($urandom_range(1) ? REQ_UNUSED_A : REQ_UNUSED_B,
                         $urandom_range(15), $urandom(), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end
    endtask

    initial begin
        now_ms         = '0;
        notice_pending = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            active[k]   = 1'b0;
            deadline[k] = '0;
            period[k]   = '0;
            recur[k]    = 1'b0;
        end
        n_failures = 0; n_requests = 0; n_results = 0; n_expiries = 0; n_notices = 0;
        idle_pct = 0; stall_pct = 0; hold_requests = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_req_type = REQ_TICK; i_slot = '0; i_period_ms = '0;
        i_recurring = 1'b0; i_restart = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, full table and a burst, zero period, shifts, bad codes
        add_req(REQ_QUERY, 0, '0, 1'b0, 1'b0);
        add_req(REQ_TICK, 0, '0, 1'b0, 1'b0);
        add_req(REQ_CANCEL, 15, '0, 1'b0, 1'b0);
        add_req(REQ_ADD, 0, 32'd0, 1'b1, 1'b0);
        add_req(REQ_TICK, 0, '0, 1'b0, 1'b0);
        add_req(REQ_ADD, 0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        for (int k = 0; k < 15; k++) add_req(REQ_ADD, k, 32'd2, k[0], 1'b0);
        add_req(REQ_ADD, 0, 32'd1, 1'b0, 1'b0);
        add_req(REQ_QUERY, 0, '0, 1'b0, 1'b0);
        add_req(REQ_RESET, 1, 32'd0, 1'b0, 1'b0);
        add_req(REQ_RESET, 2, 32'd50, 1'b0, 1'b1);
        add_req(REQ_REFRESH, 3, '0, 1'b0, 1'b0);
        add_req(REQ_TICK, 0, '0, 1'b0, 1'b0);
        add_req(REQ_TICK, 0, '0, 1'b0, 1'b0);
        add_req(REQ_UNUSED_A, 5, 32'h5555_5555, 1'b1, 1'b1);
        add_req(REQ_UNUSED_B, 10, 32'hAAAA_AAAA, 1'b0, 1'b0);
        drain();

        // random phases: free flow, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 30 : 0;
            stall_pct = (ph == 2) ? 52 : (ph == 3) ? 30 : 0;
            random_requests(40);
            // let the result side empty out before sending more
            while (request_q.size() > 20) @(posedge i_clk);
            hold_requests = 1'b1;
            while (i_valid || result_q.size() > 0) @(posedge i_clk);
            hold_requests = 1'b0;
            random_requests(40);
            drain();
        end
        repeat (80) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results (%0d expiries, %0d front notices)",
                 n_requests, n_results, n_expiries, n_notices);
        $display("Phases: free flow, sender gaps, receiver stalls, both at once");
        if (result_q.size() > 0)
            report_mismatch("missing results", '0, DELAY_W'(result_q.size()));
        if (n_failures == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4000000;
        $display("Timeout with %0d results outstanding", result_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dtq_pkg.sv
rtl/dtq_front.sv
rtl/dtq_back.sv
rtl/deadline_timer_queue_core.sv
tb/tb_deadline_timer_queue_core.sv
